// ===== rtl/alr_pkg.sv =====
// Package for the audio loop recorder/player.
// Holds operation codes, fixed field widths and the bank command type.
// No dependencies.
`default_nettype none

package alr_pkg;

	localparam int OP_W  = 3;
	localparam int CFG_W = 17;
	localparam int LEN_W = 17;

	localparam logic [CFG_W-1:0] LIMIT_RST = 17'h10000;

	localparam logic [OP_W-1:0] OP_FRAME  = 3'd0;
	localparam logic [OP_W-1:0] OP_FINISH = 3'd1;
	localparam logic [OP_W-1:0] OP_CANCEL = 3'd2;
	localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
	localparam logic [OP_W-1:0] OP_STOP   = 3'd4;
	localparam logic [OP_W-1:0] OP_TOGGLE = 3'd5;

	typedef struct packed {
		logic rd;
		logic wr;
	} bank_cmd_t;

endpackage

`default_nettype wire

// ===== rtl/alr_if.sv =====
// Request and response channel interfaces of the audio loop recorder/player.
// Depends on alr_pkg.
`default_nettype none

interface alr_req_if import alr_pkg::*; #(parameter int SAMPLE_BITS = 24) ();
	logic                          valid;
	logic                          ready;
	logic [OP_W-1:0]               operation;
	logic                          record_enable;
	logic signed [SAMPLE_BITS-1:0] rec_left;
	logic signed [SAMPLE_BITS-1:0] rec_right;
	logic signed [SAMPLE_BITS-1:0] dry_left;
	logic signed [SAMPLE_BITS-1:0] dry_right;

	modport source(output valid, operation, record_enable, rec_left, rec_right,
		dry_left, dry_right, input ready);
	modport sink(input valid, operation, record_enable, rec_left, rec_right,
		dry_left, dry_right, output ready);
endinterface

interface alr_rsp_if import alr_pkg::*; #(parameter int SAMPLE_BITS = 24) ();
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] mixed_left;
	logic signed [SAMPLE_BITS-1:0] mixed_right;
	logic                          take_open;
	logic                          overdub_on;
	logic [LEN_W-1:0]              loop_frames;

	modport source(output valid, mixed_left, mixed_right, take_open,
		overdub_on, loop_frames, input ready);
	modport sink(input valid, mixed_left, mixed_right, take_open,
		overdub_on, loop_frames, output ready);
endinterface

`default_nettype wire

// ===== rtl/alr_bank.sv =====
// One frame bank: single-port synchronous RAM with a registered read.
// Depends on alr_pkg (bank_cmd_t).
`default_nettype none

module alr_bank import alr_pkg::*; #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16,
	parameter int DW    = 48
) (
	input  wire logic          clk,
	input  wire bank_cmd_t     cmd,
	input  wire logic [AW-1:0] addr,
	input  wire logic [DW-1:0] wdata,
	output logic      [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			mem[addr] <= wdata;
		end
		if (cmd.rd) begin
			rdata <= mem[addr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/audio_loop_recorder_player_top.sv =====
// Top level of the audio loop recorder/player: two frame banks, heads and mixer.
// Depends on alr_pkg, alr_if (alr_req_if, alr_rsp_if) and alr_bank.
//
//  channel | dir | handshake          | carries
//  req     | in  | valid/ready        | operation, record_enable, rec_*, dry_*
//  rsp     | out | valid/ready        | mixed_*, take_open, overdub_on, loop_frames
//  cfg     | in  | cfg_we (no ready)  | record_limit
//
// Each word takes three steps: accept plus play-head read, record-head read plus
// mix, then overdub sum, shadow-bank write and head update; both reads share the
// active bank's single port. After arst_n both banks are zeroed, one entry per
// cycle, req.ready low until all MAX_FRAMES entries are clear. The result register
// lets a new word in while a result waits; it holds in ST_S2 until rsp drains.
`default_nettype none

module audio_loop_recorder_player_top import alr_pkg::*; #(
	parameter int MAX_FRAMES  = 65536,
	parameter int CHANNELS    = 2,
	parameter int SAMPLE_BITS = 24
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	alr_req_if.sink               req,
	alr_rsp_if.source             rsp,
	input  wire logic             cfg_we,
	input  wire logic [CFG_W-1:0] cfg_wdata
);

	localparam int SB = SAMPLE_BITS;
	localparam int AW = $clog2(MAX_FRAMES);
	localparam int HW = $clog2(MAX_FRAMES + 1);
	localparam int DW = CHANNELS * SB;

	localparam logic signed [SB-1:0] SMAX = {1'b0, {(SB-1){1'b1}}};
	localparam logic signed [SB-1:0] SMIN = {1'b1, {(SB-1){1'b0}}};

	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_S1   = 2'd2;
	localparam logic [1:0] ST_S2   = 2'd3;

	function automatic logic signed [SB-1:0] sat_add(input logic signed [SB-1:0] a,
		input logic signed [SB-1:0] b);
		logic signed [SB:0] s;
		s = {a[SB-1], a} + {b[SB-1], b};
		if (s[SB] != s[SB-1]) begin
			return s[SB] ? SMIN : SMAX;
		end
		return s[SB-1:0];
	endfunction

	logic [1:0]        state_q;
	logic [AW-1:0]     clr_idx_q;
	logic              active_q;
	logic              overdub_q;
	logic [HW-1:0]     rec_head_q;
	logic [HW-1:0]     play_head_q;
	logic [HW-1:0]     loop_len_q;
	logic [CFG_W-1:0]  limit_q;

	logic [OP_W-1:0]   op_q;
	logic              rec_en_q;
	logic signed [SB-1:0] rec_q [2];
	logic signed [SB-1:0] dry_q [2];
	logic signed [SB-1:0] mix_s2 [2];

	logic              out_valid_q;
	logic signed [SB-1:0] out_mixed_q [2];
	logic              out_still_q;
	logic              out_od_q;
	logic [LEN_W-1:0]  out_loop_q;

	bank_cmd_t         cmd0, cmd1;
	logic [AW-1:0]     bank_addr;
	logic [DW-1:0]     bank_wdata;
	logic [DW-1:0]     rd0, rd1, act_rd;
	logic [DW-1:0]     wdata;

	logic signed [SB-1:0] act_smp [2];
	logic signed [SB-1:0] mix_nx [2];
	logic signed [SB-1:0] wr_smp [2];

	logic              accept, adv;
	logic [HW-1:0]     lim;
	logic              rec_fits, rec_ending, rec_write;
	logic [HW-1:0]     rec_head_n, play_head_n, loop_len_n;
	logic              active_n, overdub_n, still_n;

	assign accept   = req.valid && req.ready;
	assign req.ready = (state_q == ST_IDLE);
	assign adv      = (state_q == ST_S2) && (!out_valid_q || rsp.ready);
	assign act_rd   = active_q ? rd1 : rd0;

	assign lim = (32'(limit_q) > 32'(MAX_FRAMES)) ? HW'(MAX_FRAMES) : HW'(limit_q);
	assign rec_fits   = (rec_head_q < lim);
	assign rec_ending = (({1'b0, rec_head_q} + 1'b1) >= {1'b0, lim});
	assign rec_write  = adv && (op_q == OP_FRAME) && rec_en_q && rec_fits;

	for (genvar c = 0; c < 2; c++) begin : g_ch
		if (c < CHANNELS) begin : g_on
			assign act_smp[c] = act_rd[c*SB +: SB];
			assign wdata[c*SB +: SB] = wr_smp[c];
			assign mix_nx[c] = (loop_len_q != '0) ? sat_add(dry_q[c], act_smp[c]) : dry_q[c];
		end else begin : g_off
			assign act_smp[c] = '0;
			assign mix_nx[c]  = dry_q[c];
		end
		assign wr_smp[c] = overdub_q ? sat_add(rec_q[c], act_smp[c]) : rec_q[c];
	end

	always_comb begin
		cmd0       = '0;
		cmd1       = '0;
		bank_addr  = clr_idx_q;
		bank_wdata = '0;
		case (state_q)
			ST_CLR: begin
				cmd0.wr = 1'b1;
				cmd1.wr = 1'b1;
			end
			ST_IDLE: begin
				cmd0.rd   = accept;
				cmd1.rd   = accept;
				bank_addr = play_head_q[AW-1:0];
			end
			ST_S1: begin
				cmd0.rd   = 1'b1;
				cmd1.rd   = 1'b1;
				bank_addr = rec_head_q[AW-1:0];
			end
			ST_S2: begin
				cmd0.wr    = rec_write && active_q;
				cmd1.wr    = rec_write && !active_q;
				bank_addr  = rec_head_q[AW-1:0];
				bank_wdata = wdata;
			end
			default: begin
			end
		endcase
	end

	alr_bank #(.DEPTH(MAX_FRAMES), .AW(AW), .DW(DW)) u_bank0 (
		.clk   (clk),
		.cmd   (cmd0),
		.addr  (bank_addr),
		.wdata (bank_wdata),
		.rdata (rd0)
	);

	alr_bank #(.DEPTH(MAX_FRAMES), .AW(AW), .DW(DW)) u_bank1 (
		.clk   (clk),
		.cmd   (cmd1),
		.addr  (bank_addr),
		.wdata (bank_wdata),
		.rdata (rd1)
	);

	always_comb begin
		rec_head_n  = rec_head_q;
		play_head_n = play_head_q;
		loop_len_n  = loop_len_q;
		active_n    = active_q;
		overdub_n   = overdub_q;
		still_n     = 1'b1;
		case (op_q)
			OP_FRAME: begin
				if (loop_len_q != '0) begin
					play_head_n = (({1'b0, play_head_q} + 1'b1) >= {1'b0, loop_len_q}) ?
						'0 : play_head_q + 1'b1;
				end
				if (rec_en_q) begin
					if (rec_fits) begin
						rec_head_n = rec_head_q + 1'b1;
					end
					if (rec_ending) begin
						still_n     = 1'b0;
						loop_len_n  = rec_head_n;
						rec_head_n  = '0;
						play_head_n = '0;
						active_n    = !active_q;
					end
				end
			end
			OP_FINISH: begin
				loop_len_n  = rec_head_q;
				rec_head_n  = '0;
				play_head_n = '0;
				active_n    = !active_q;
			end
			OP_CANCEL: begin
				rec_head_n = '0;
			end
			OP_CLEAR: begin
				loop_len_n  = '0;
				rec_head_n  = '0;
				play_head_n = '0;
			end
			OP_STOP: begin
				play_head_n = '0;
			end
			OP_TOGGLE: begin
				overdub_n = !overdub_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLR;
			clr_idx_q   <= '0;
			active_q    <= 1'b0;
			overdub_q   <= 1'b0;
			rec_head_q  <= '0;
			play_head_q <= '0;
			loop_len_q  <= '0;
			limit_q     <= LIMIT_RST;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			case (state_q)
				ST_CLR: begin
					clr_idx_q <= clr_idx_q + 1'b1;
					if (clr_idx_q == AW'(MAX_FRAMES - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_S1;
					end
				end
				ST_S1: begin
					state_q <= ST_S2;
				end
				ST_S2: begin
					if (adv) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (adv) begin
				rec_head_q  <= rec_head_n;
				play_head_q <= play_head_n;
				loop_len_q  <= loop_len_n;
				active_q    <= active_n;
				overdub_q   <= overdub_n;
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q     <= req.operation;
			rec_en_q <= req.record_enable;
			rec_q[0] <= req.rec_left;
			rec_q[1] <= req.rec_right;
			dry_q[0] <= req.dry_left;
			dry_q[1] <= req.dry_right;
		end
		if (state_q == ST_S1) begin
			mix_s2[0] <= mix_nx[0];
			mix_s2[1] <= mix_nx[1];
		end
		if (adv) begin
			out_mixed_q[0] <= (op_q == OP_FRAME) ? mix_s2[0] : '0;
			out_mixed_q[1] <= (op_q == OP_FRAME) ? mix_s2[1] : '0;
			out_still_q    <= still_n;
			out_od_q       <= overdub_n;
			out_loop_q     <= LEN_W'(loop_len_n);
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.mixed_left  = out_mixed_q[0];
	assign rsp.mixed_right = out_mixed_q[1];
	assign rsp.take_open   = out_still_q;
	assign rsp.overdub_on  = out_od_q;
	assign rsp.loop_frames = out_loop_q;

endmodule

`default_nettype wire

// ===== rtl/alr_checker.sv =====
// Port-level checker for the audio loop recorder/player, bound to the top level.
// Depends on alr_pkg (operation codes, widths).
`default_nettype none

module alr_checker import alr_pkg::*; #(
	parameter int SAMPLE_BITS = 24
) (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   req_valid,
	input wire logic                   req_ready,
	input wire logic [OP_W-1:0]        req_operation,
	input wire logic                   rsp_valid,
	input wire logic                   rsp_ready,
	input wire logic [SAMPLE_BITS-1:0] rsp_mixed_left,
	input wire logic [SAMPLE_BITS-1:0] rsp_mixed_right,
	input wire logic                   rsp_take_open,
	input wire logic                   rsp_overdub_on,
	input wire logic [LEN_W-1:0]       rsp_loop_frames
);

	logic            push, pop;
	logic [OP_W-1:0] op0_q, op1_q;
	logic [1:0]      cnt_q;
	logic            prev_od_q;

	assign push = req_valid && req_ready;
	assign pop  = rsp_valid && rsp_ready;

	// ops of words accepted whose results are not yet taken, oldest in op0_q
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op0_q     <= OP_FRAME;
			op1_q     <= OP_FRAME;
			cnt_q     <= 2'd0;
			prev_od_q <= 1'b0;
		end else begin
			if (pop) begin
				prev_od_q <= rsp_overdub_on;
			end
			if (push && pop) begin
				if (cnt_q == 2'd1) begin
					op0_q <= req_operation;
				end else begin
					op0_q <= op1_q;
					op1_q <= req_operation;
				end
			end else if (push) begin
				if (cnt_q == 2'd0) begin
					op0_q <= req_operation;
				end else begin
					op1_q <= req_operation;
				end
				cnt_q <= cnt_q + 2'd1;
			end else if (pop) begin
				op0_q <= op1_q;
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		push |=> !req_ready)
		else $error("req.ready high in the cycle after a word was taken");

	a_nonframe_result: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && op0_q != OP_FRAME) |->
			(rsp_mixed_left == '0 && rsp_mixed_right == '0 && rsp_take_open))
		else $error("non-frame result carries samples or an ended take");

	a_overdub_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> ((rsp_overdub_on != prev_od_q) == (op0_q == OP_TOGGLE)))
		else $error("overdub mode changed without a toggle, or toggle lost");

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && op0_q == OP_CLEAR) |-> (rsp_loop_frames == '0))
		else $error("loop length not zero after clear");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=>
			(rsp_valid && $stable(rsp_mixed_left) && $stable(rsp_loop_frames)))
		else $error("stalled result word changed");

endmodule

bind audio_loop_recorder_player_top alr_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_alr_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.req_valid       (req.valid),
	.req_ready       (req.ready),
	.req_operation   (req.operation),
	.rsp_valid       (rsp.valid),
	.rsp_ready       (rsp.ready),
	.rsp_mixed_left  (rsp.mixed_left),
	.rsp_mixed_right (rsp.mixed_right),
	.rsp_take_open   (rsp.take_open),
	.rsp_overdub_on  (rsp.overdub_on),
	.rsp_loop_frames (rsp.loop_frames)
);

`default_nettype wire
